[rtl/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the radix string converter
// Status codes, radix codes, register indexes, character codes and small
// helper functions used by the front end and the back end.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int RSC_VALUE_WIDTH   = 64;
    localparam int RSC_MAX_OUT_CHARS = 64;
    localparam int RSC_QUEUE_DEPTH   = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_BASE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ADD_ONE     = 2'd2;

    // radix codes
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_Z_UP   = 8'h5A;
    localparam logic [7:0] CH_A_LOW  = 8'h61;
    localparam logic [7:0] CH_Z_LOW  = 8'h7A;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_X_LOW  = 8'h78;

    localparam logic [5:0] DIGIT_NONE = 6'd63;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NEG     = 3'd1,
        ST_INVALID = 3'd2,
        ST_LARGE   = 3'd3,
        ST_ATMAX   = 3'd4
    } status_t;

    // control part of one conversion job
    typedef struct packed {
        status_t    code;
        logic [1:0] base;
    } rsc_job_t;

    function automatic logic [4:0] radix_value(logic [1:0] base);
        logic [4:0] r;
        unique case (base)
            BASE_BIN: r = 5'd2;
            BASE_OCT: r = 5'd8;
            BASE_DEC: r = 5'd10;
            default:  r = 5'd16;
        endcase
        return r;
    endfunction

    // alphanumeric digit value 0..35, DIGIT_NONE otherwise
    function automatic logic [5:0] digit_value(logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
        end
        else if (c >= CH_A_LOW && c <= CH_Z_LOW) begin
            t = c - CH_A_LOW + 8'd10;
        end
        else if (c >= CH_A_UP && c <= CH_Z_UP) begin
            t = c - CH_A_UP + 8'd10;
        end
        else begin
            t = {2'b00, DIGIT_NONE};
        end
        return t[5:0];
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] digit_char(logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CH_ZERO + {4'b0000, d};
        end
        else begin
            r = CH_A_UP + {4'b0000, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

[rtl/rsc_ifs.sv]
// ----------------------------------------------------------------------------
// rsc_ifs: stream channels of the radix string converter
// Character input channel and digit output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_string;

    modport source (output valid, output character, output end_of_string, input ready);
    modport sink   (input valid, input character, input end_of_string, output ready);
endinterface

interface rsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_char, output status, output last, input ready);
    modport sink   (input valid, input out_char, input status, input last, output ready);
endinterface

[rtl/rsc_front.sv]
// ----------------------------------------------------------------------------
// rsc_front: character parser
// Holds the configuration registers, parses one character per cycle into
// acc_reg unless the queue is full and, on the terminator, pushes one job.
// ----------------------------------------------------------------------------
module rsc_front
    import rsc_pkg::*;
#(
    parameter int W = RSC_VALUE_WIDTH
)(
    input  logic                   clk,
    input  logic                   rst_n,
    rsc_in_if.sink                 in_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   queue_full,
    output logic                   push,
    output logic [W-1:0]           job_value,
    output rsc_job_t               job_ctrl
);

    localparam int EW = W + 4;

    typedef enum logic [6:0] {
        PH_START  = 7'b0000001,
        PH_SPACE  = 7'b0000010,
        PH_SIGN   = 7'b0000100,
        PH_ZERO   = 7'b0001000,
        PH_PREFIX = 7'b0010000,
        PH_DIGITS = 7'b0100000,
        PH_STOP   = 7'b1000000
    } phase_t;

    logic [1:0]    source_base_reg;
    logic [1:0]    target_base_reg;
    logic          add_one_reg;

    logic [W-1:0]  acc_reg, acc_next;
    status_t       err_reg, err_next;
    phase_t        phase_reg, phase_next;

    logic          accept;
    logic [7:0]    c;
    logic [5:0]    dig;
    logic          dig_ok;
    logic          hex;
    logic [EW-1:0] ext;
    logic          overflow;
    logic          route;
    status_t       term_code;
    logic [W-1:0]  term_value;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign c           = in_ch.character;
    assign dig         = digit_value(c);
    assign dig_ok      = dig < {1'b0, radix_value(source_base_reg)};
    assign hex         = (source_base_reg == BASE_HEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_base_reg <= BASE_DEC;
            target_base_reg <= BASE_HEX;
            add_one_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_BASE: source_base_reg <= cfg_data[1:0];
                REG_TARGET_BASE: target_base_reg <= cfg_data[1:0];
                REG_ADD_ONE:     add_one_reg     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // acc * radix + digit, extended so that overflow shows in the top bits
    always_comb
    begin
        unique case (source_base_reg)
            BASE_BIN: ext = {4'b0000, acc_reg} << 1;
            BASE_OCT: ext = {4'b0000, acc_reg} << 3;
            BASE_DEC: ext = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1);
            default:  ext = {4'b0000, acc_reg} << 4;
        endcase
        ext = ext + EW'(dig);
    end

    assign overflow = |ext[EW-1:W];

    // terminator: the space, sign and prefix phases, which never saw a digit, are invalid; minus wins
    always_comb
    begin
        term_code  = err_reg;
        term_value = acc_reg;
        if ((phase_reg == PH_SPACE || phase_reg == PH_SIGN || phase_reg == PH_PREFIX)
            && err_reg != ST_NEG)
        begin
            term_code = ST_INVALID;
        end
        if (term_code == ST_OK && add_one_reg)
        begin
            if (&acc_reg)
            begin
                term_code = ST_ATMAX;
            end
            else
            begin
                term_value = acc_reg + W'(1);
            end
        end
    end

    assign job_value     = term_value;
    assign job_ctrl.code = term_code;
    assign job_ctrl.base = target_base_reg;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        push       = 1'b0;
        route      = 1'b0;
        if (accept)
        begin
            if (in_ch.end_of_string)
            begin
                push       = 1'b1;
                acc_next   = '0;
                err_next   = ST_OK;
                phase_next = PH_START;
            end
            else if (c == CH_MINUS)
            begin
                err_next   = ST_NEG;
                phase_next = PH_STOP;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START, PH_SPACE:
                    begin
                        if (is_space(c))
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (c == CH_PLUS)
                        begin
                            phase_next = PH_SIGN;
                        end
                        else if (hex && c == CH_ZERO)
                        begin
                            phase_next = PH_ZERO;
                        end
                        else
                        begin
                            route = 1'b1;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (hex && c == CH_ZERO)
                        begin
                            phase_next = PH_ZERO;
                        end
                        else
                        begin
                            route = 1'b1;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (c == CH_X_LOW || c == CH_X_UP)
                        begin
                            phase_next = PH_PREFIX;
                        end
                        else
                        begin
                            route = 1'b1;
                        end
                    end
                    PH_PREFIX, PH_DIGITS:
                    begin
                        route = 1'b1;
                    end
                    default: ;
                endcase
                if (route)
                begin
                    if (dig_ok)
                    begin
                        phase_next = PH_DIGITS;
                        if (err_reg == ST_OK)
                        begin
                            if (overflow)
                            begin
                                err_next = ST_LARGE;
                            end
                            else
                            begin
                                acc_next = ext[W-1:0];
                            end
                        end
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                        if (err_reg != ST_NEG)
                        begin
                            err_next = ST_INVALID;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            err_reg   <= ST_OK;
            phase_reg <= PH_START;
        end
        else
        begin
            acc_reg   <= acc_next;
            err_reg   <= err_next;
            phase_reg <= phase_next;
        end
    end

    // a job never leaves the parser with a value beyond the limit unflagged
    a_large_stops_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg == ST_LARGE && accept && !in_ch.end_of_string) |=> $stable(acc_reg))
        else $error("accumulator changed after overflow");

endmodule

[rtl/rsc_queue.sv]
// ----------------------------------------------------------------------------
// rsc_queue: job queue between parser and converter
// Small register FIFO; lets the parser take the next string while the
// converter still emits the previous result.
// ----------------------------------------------------------------------------
module rsc_queue
    import rsc_pkg::*;
#(
    parameter int DATA_W = RSC_VALUE_WIDTH + $bits(rsc_job_t),
    parameter int DEPTH  = RSC_QUEUE_DEPTH
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> !empty)
        else $error("pushed item not visible");

endmodule

[rtl/rsc_back.sv]
// ----------------------------------------------------------------------------
// rsc_back: number-to-text converter
// Takes one job, builds its digits (bit slices for binary, octal and hex,
// shift-add-3 for decimal), skips leading zeros and emits the digits most
// significant first through an output register; an error job gives one NUL item.
// ----------------------------------------------------------------------------
module rsc_back
    import rsc_pkg::*;
#(
    parameter int W    = RSC_VALUE_WIDTH,
    parameter int MAXC = RSC_MAX_OUT_CHARS
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_valid,
    input  logic [W-1:0] job_value,
    input  rsc_job_t     job_ctrl,
    output logic         pop,
    rsc_out_if.source    out_ch
);

    localparam int N8    = (W + 2) / 3;
    localparam int N16   = (W + 3) / 4;
    localparam int ND    = (W * 30103) / 100000 + 1;
    localparam int PW8   = 3 * N8;
    localparam int PW16  = 4 * N16;
    localparam int PWD   = 4 * ND;
    localparam int WA    = (PW8 > W) ? PW8 : W;
    localparam int WB    = (PW16 > WA) ? PW16 : WA;
    localparam int WR    = (PWD > WB) ? PWD : WB;
    localparam int PCW   = $clog2(W);
    localparam int LIMIT = (MAXC < W) ? MAXC : W;
    localparam logic [PCW:0] LIMIT_V = (PCW + 1)'(LIMIT);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DABBLE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_EMIT   = 5'b01000,
        S_ERR    = 5'b10000
    } bstate_t;

    bstate_t          state_reg, state_next;
    logic [PCW-1:0]   pos_reg, pos_next;
    logic [1:0]       base_reg, base_next;
    status_t          code_reg, code_next;
    logic [WR-1:0]    work_reg, work_next;
    logic [PWD-1:0]   dec_digits_reg, dec_digits_next;
    logic [PWD-1:0]   dec_adj;
    logic             trunc_reg, trunc_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    status_t          out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;

    logic             out_space;
    logic [3:0]       top_digit;
    logic [WR-1:0]    work_shifted;

    assign out_space       = !out_valid_reg || out_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_char = out_char_reg;
    assign out_ch.status   = out_status_reg;
    assign out_ch.last     = out_last_reg;

    // digits sit at the top of the work register, one step moves one digit
    always_comb
    begin
        unique case (base_reg)
            BASE_BIN:
            begin
                top_digit    = {3'b000, work_reg[WR-1]};
                work_shifted = work_reg << 1;
            end
            BASE_OCT:
            begin
                top_digit    = {1'b0, work_reg[WR-1 -: 3]};
                work_shifted = work_reg << 3;
            end
            default:
            begin
                top_digit    = work_reg[WR-1 -: 4];
                work_shifted = work_reg << 4;
            end
        endcase
    end

    // add 3 to every BCD digit of 5 or more before the next shift
    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            dec_adj[4*i +: 4] = (dec_digits_reg[4*i +: 4] >= 4'd5) ?
                                dec_digits_reg[4*i +: 4] + 4'd3 :
                                dec_digits_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        base_next       = base_reg;
        code_next       = code_reg;
        work_next       = work_reg;
        dec_digits_next = dec_digits_reg;
        trunc_next      = trunc_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    pop        = 1'b1;
                    base_next  = job_ctrl.base;
                    code_next  = job_ctrl.code;
                    trunc_next = 1'b0;
                    if (job_ctrl.code != ST_OK)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        unique case (job_ctrl.base)
                            BASE_BIN:
                            begin
                                work_next  = WR'(job_value) << (WR - W);
                                pos_next   = PCW'(W - 1);
                                state_next = S_SCAN;
                            end
                            BASE_OCT:
                            begin
                                work_next  = WR'(job_value) << (WR - PW8);
                                pos_next   = PCW'(N8 - 1);
                                state_next = S_SCAN;
                            end
                            BASE_DEC:
                            begin
                                work_next       = WR'(job_value);
                                dec_digits_next = '0;
                                pos_next        = PCW'(W - 1);
                                state_next      = S_DABBLE;
                            end
                            default:
                            begin
                                work_next  = WR'(job_value) << (WR - PW16);
                                pos_next   = PCW'(N16 - 1);
                                state_next = S_SCAN;
                            end
                        endcase
                    end
                end
            end
            S_DABBLE:
            begin
                dec_digits_next = {dec_adj[PWD-2:0], work_reg[W-1]};
                work_next       = work_reg << 1;
                if (pos_reg == '0)
                begin
                    work_next  = WR'(dec_digits_next) << (WR - PWD);
                    pos_next   = PCW'(ND - 1);
                    state_next = S_SCAN;
                end
                else
                begin
                    pos_next = pos_reg - PCW'(1);
                end
            end
            S_SCAN:
            begin
                // digits above the output limit are dropped; a nonzero one
                // among them cuts the run, which then keeps its leading zeros
                if ({1'b0, pos_reg} >= LIMIT_V)
                begin
                    trunc_next = trunc_reg || (top_digit != 4'd0);
                    work_next  = work_shifted;
                    pos_next   = pos_reg - PCW'(1);
                end
                else if (top_digit == 4'd0 && pos_reg != '0 && !trunc_reg)
                begin
                    work_next = work_shifted;
                    pos_next  = pos_reg - PCW'(1);
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_space)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = digit_char(top_digit);
                    out_status_next = ST_OK;
                    out_last_next   = (pos_reg == '0);
                    work_next       = work_shifted;
                    if (pos_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - PCW'(1);
                    end
                end
            end
            S_ERR:
            begin
                if (out_space)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = CH_NUL;
                    out_status_next = code_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        base_reg       <= base_next;
        code_reg       <= code_next;
        work_reg       <= work_next;
        dec_digits_reg <= dec_digits_next;
        trunc_reg      <= trunc_next;
        out_char_reg   <= out_char_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    a_dabble_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DABBLE) |-> (base_reg == BASE_DEC))
        else $error("BCD pass on a non-decimal job");

    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_space && pos_reg == '0)
        |=> (out_valid_reg && out_last_reg && state_reg == S_IDLE))
        else $error("final digit not marked last");

    a_error_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_last_reg && out_char_reg == CH_NUL))
        else $error("error item malformed");

endmodule

[rtl/radix_string_converter_unit.sv]
// ----------------------------------------------------------------------------
// radix_string_converter_unit: ASCII number to ASCII number in another radix
// Parser front end, two-entry job queue, converter back end.
//
//   channel  | role   | payload                      | accepted when
//   ---------+--------+------------------------------+------------------------
//   in_ch    | sink   | character, end_of_string     | valid && ready
//   out_ch   | source | out_char, status, last       | valid && ready
//   cfg      | write  | cfg_index, cfg_data          | cfg_we high
//
// Characters are taken one per cycle; the terminator pushes a job in the
// same cycle. In the back end a decimal job first runs shift-add-3 over
// its W value bits; the scan drops leading zeros one digit per cycle and
// S_EMIT sends the rest of the N digit positions of the target radix (W,
// ceil(W/3), 20 for W=64, ceil(W/4)). Output stalls hold S_EMIT and S_ERR.
// Input stalls only while the job queue is full; output holds in a register.
// rst_n is asynchronous, active low, and clears parser, queue and FSM state.
// ----------------------------------------------------------------------------
module radix_string_converter_unit
    import rsc_pkg::*;
#(
    parameter int VALUE_WIDTH   = RSC_VALUE_WIDTH,
    parameter int MAX_OUT_CHARS = RSC_MAX_OUT_CHARS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    rsc_in_if.sink                 in_ch,
    rsc_out_if.source              out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int JOB_W = VALUE_WIDTH + $bits(rsc_job_t);

    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_empty;
    logic [VALUE_WIDTH-1:0] push_value;
    rsc_job_t               push_ctrl;
    logic [JOB_W-1:0]       pop_data;
    rsc_job_t               pop_ctrl;

    rsc_front #(
        .W (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .job_value  (push_value),
        .job_ctrl   (push_ctrl)
    );

    rsc_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (RSC_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctrl, push_value}),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    assign pop_ctrl = pop_data[JOB_W-1:VALUE_WIDTH];

    rsc_back #(
        .W    (VALUE_WIDTH),
        .MAXC (MAX_OUT_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!queue_empty),
        .job_value (pop_data[VALUE_WIDTH-1:0]),
        .job_ctrl  (pop_ctrl),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule
